@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define APT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define APT_ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error("assertion failed");
`else
`define APT_ASSERT(lbl, clk, rst_n, prop)
`define APT_ASSERT_IMPL(lbl, clk, rst_n, pre, post)
`endif
`endif

@@ design/apt_pkg.sv @@
// ----------------------------------------------------------------------------
// apt_pkg
// types, widths and constants of the affine point transform
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package apt_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CW        = 32;
  localparam int VW        = CW + 1;
  localparam int PW        = CW + VW;
  localparam int AW        = PW + 2;
  localparam int MW        = 2 * CW;
  localparam int QW        = CW;
  localparam int RW        = 2 * CW;
  localparam int NCFG      = 8;
  localparam int CFG_IW    = 3;
  localparam int DIV_STAGES = QW + 1;

  localparam logic [CW-1:0] ONE  = CW'(1) << FRAC_BITS;
  localparam logic [CW-1:0] SMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] SMIN = {1'b1, {(CW-1){1'b0}}};

  typedef enum logic [2:0] {
    OP_AFFINE    = 3'd0,
    OP_ROT       = 3'd1,
    OP_INV_RIGID = 3'd2,
    OP_TRANS_ROT = 3'd3,
    OP_PROJ      = 3'd4
  } apt_op_e;

  typedef struct packed {
    logic [2:0]           opcode;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic signed [CW-1:0] pz;
  } apt_in_t;

  typedef struct packed {
    logic signed [CW-1:0] qx;
    logic signed [CW-1:0] qy;
    logic signed [CW-1:0] qz;
    logic                 zero_divisor;
    logic                 saturated;
  } apt_out_t;

  typedef struct packed {
    logic [MW-1:0] rem;
    logic [QW-1:0] qn;
    logic          ovf;
    logic          neg;
  } apt_lane_t;

  typedef struct packed {
    logic                proj;
    logic                zdiv;
    logic                sat_np;
    logic [2:0][CW-1:0]  q_np;
  } apt_meta_t;

  typedef struct packed {
    apt_lane_t [2:0] lane;
    logic [MW-1:0]   dm;
    apt_meta_t       meta;
  } apt_div_t;

  function automatic logic [RW-1:0] cfg_reset(input int idx);
    logic [RW-1:0] v;
    int            r;
    int            c0;
    v  = '0;
    r  = idx >> 1;
    c0 = (idx & 1) * 2;
    if (r == c0) begin
      v[CW-1:0] = ONE;
    end
    if (r == c0 + 1) begin
      v[RW-1:CW] = ONE;
    end
    return v;
  endfunction

endpackage

@@ design/apt_dot.sv @@
// ----------------------------------------------------------------------------
// apt_dot
// one matrix row: three registered products, then a registered exact sum
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module apt_dot (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic [2:0][apt_pkg::CW-1:0]           a_i,
  input  logic [2:0][apt_pkg::VW-1:0]           v_i,
  input  logic [apt_pkg::CW-1:0]                t_i,
  output logic [apt_pkg::AW-1:0]                acc_o
);

  logic signed [apt_pkg::PW-1:0] prod_d [3];
  logic signed [apt_pkg::PW-1:0] prod_q [3];
  logic [apt_pkg::CW-1:0]        t_q;
  logic signed [apt_pkg::AW-1:0] tx;
  logic signed [apt_pkg::AW-1:0] acc_d;
  logic [apt_pkg::AW-1:0]        acc_q;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      prod_d[l] = $signed(a_i[l]) * $signed(v_i[l]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < 3; l++) begin
        prod_q[l] <= prod_d[l];
      end
      t_q <= t_i;
    end
  end

  always_comb begin
    tx    = {{(apt_pkg::AW-apt_pkg::CW){t_q[apt_pkg::CW-1]}}, t_q};
    acc_d = prod_q[0] + prod_q[1] + prod_q[2] + (tx <<< apt_pkg::FRAC_BITS);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

@@ design/apt_div.sv @@
// ----------------------------------------------------------------------------
// apt_div
// three-lane restoring divider, an overflow check then one quotient bit
// per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module apt_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  apt_pkg::apt_div_t  data_i,
  output logic               valid_o,
  output apt_pkg::apt_div_t  data_o
);

  localparam int DS = apt_pkg::DIV_STAGES;

  logic [DS-1:0]     vld_q;
  apt_pkg::apt_div_t stg_q [DS];

  function automatic apt_pkg::apt_div_t div_pre(input apt_pkg::apt_div_t s);
    apt_pkg::apt_div_t n;
    n = s;
    for (int l = 0; l < 3; l++) begin
      n.lane[l].ovf = (s.lane[l].rem >= s.dm);
    end
    return n;
  endfunction

  function automatic apt_pkg::apt_div_t div_step(input apt_pkg::apt_div_t s);
    apt_pkg::apt_div_t   n;
    logic [apt_pkg::MW:0] t;
    logic [apt_pkg::MW:0] d;
    n = s;
    for (int l = 0; l < 3; l++) begin
      t = {s.lane[l].rem, s.lane[l].qn[apt_pkg::QW-1]};
      d = t - {1'b0, s.dm};
      n.lane[l].rem = d[apt_pkg::MW] ? t[apt_pkg::MW-1:0] : d[apt_pkg::MW-1:0];
      n.lane[l].qn  = {s.lane[l].qn[apt_pkg::QW-2:0], ~d[apt_pkg::MW]};
    end
    return n;
  endfunction

  for (genvar k = 0; k < DS; k++) begin : g_stage
    apt_pkg::apt_div_t stg_d;
    logic              src_v;
    if (k == 0) begin : g_first
      assign stg_d = div_pre(data_i);
      assign src_v = valid_i;
    end else begin : g_step
      assign stg_d = div_step(stg_q[k-1]);
      assign src_v = vld_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stg_q[k] <= stg_d;
      end
    end
  end

  assign valid_o = vld_q[DS-1];
  assign data_o  = stg_q[DS-1];

  `APT_ASSERT_IMPL(a_vld_shift, clk_i, rst_ni, en_i, ##1 (vld_q[DS-1:1] == $past(vld_q[DS-2:0])))
  `APT_ASSERT_IMPL(a_vld_hold, clk_i, rst_ni, !en_i, ##1 $stable(vld_q))

endmodule

@@ design/affine_point_transform.sv @@
// ----------------------------------------------------------------------------
// affine_point_transform
// 4x4 fixed-point matrix transform of 3d points, one item per unstalled clock
// ----------------------------------------------------------------------------
// Takes one point per clock unless a valid output is stalled. Its stages are
// one input register, a product stage, an exact sum stage, a sign and
// saturation stage, then a 33-stage restoring divider (an overflow check and
// one quotient bit per stage) that sets the depth, and the output register.
// Every opcode walks the same pipeline, so results leave in order. A stall on
// a valid output holds the whole pipeline and raises the input stall. The user
// must write matrix registers only while idle; the block does not enforce it.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module affine_point_transform (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  apt_pkg::apt_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output apt_pkg::apt_out_t             out_data_o,
  input  logic                          cfg_we_i,
  input  logic [apt_pkg::CFG_IW-1:0]    cfg_idx_i,
  input  logic [apt_pkg::RW-1:0]        cfg_data_i
);

  localparam int CW = apt_pkg::CW;
  localparam int VW = apt_pkg::VW;
  localparam int AW = apt_pkg::AW;
  localparam int MW = apt_pkg::MW;
  localparam int QW = apt_pkg::QW;
  localparam int F  = apt_pkg::FRAC_BITS;

  logic                  en;
  logic [apt_pkg::RW-1:0] cfg_q [apt_pkg::NCFG];
  logic [CW-1:0]          m [4][4];

  // matrix registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < apt_pkg::NCFG; i++) begin
        cfg_q[i] <= apt_pkg::cfg_reset(i);
      end
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  for (genvar r = 0; r < 4; r++) begin : g_mr
    for (genvar c = 0; c < 4; c++) begin : g_mc
      assign m[r][c] = cfg_q[2*r + c/2][CW*(c%2) +: CW];
    end
  end

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // input stage: operand selection
  logic [CW-1:0]            p [3];
  logic [3:0][2:0][CW-1:0]  a_d, a_q;
  logic [3:0][2:0][VW-1:0]  v_d, v_q;
  logic [3:0][CW-1:0]       t_d, t_q;
  logic                     trans, sub, addt;
  logic [2:0]               op_q [3];
  logic [2:0]               vld_q;

  assign p[0] = in_data_i.px;
  assign p[1] = in_data_i.py;
  assign p[2] = in_data_i.pz;

  always_comb begin
    trans = (in_data_i.opcode == apt_pkg::OP_INV_RIGID) ||
            (in_data_i.opcode == apt_pkg::OP_TRANS_ROT);
    sub   = (in_data_i.opcode == apt_pkg::OP_INV_RIGID);
    addt  = (in_data_i.opcode == apt_pkg::OP_AFFINE) ||
            (in_data_i.opcode == apt_pkg::OP_PROJ);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        a_d[i][j] = trans ? m[j][i] : m[i][j];
        v_d[i][j] = sub ? ({p[j][CW-1], p[j]} - {m[j][3][CW-1], m[j][3]})
                        : {p[j][CW-1], p[j]};
      end
      t_d[i] = addt ? m[i][3] : '0;
    end
    for (int j = 0; j < 3; j++) begin
      a_d[3][j] = m[3][j];
      v_d[3][j] = {p[j][CW-1], p[j]};
    end
    t_d[3] = m[3][3];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q      <= a_d;
      v_q      <= v_d;
      t_q      <= t_d;
      op_q[0]  <= in_data_i.opcode;
      op_q[1]  <= op_q[0];
      op_q[2]  <= op_q[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[1:0], in_valid_i};
    end
  end

  // products and sums
  logic [AW-1:0] acc [4];

  for (genvar r = 0; r < 4; r++) begin : g_row
    apt_dot u_dot (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (a_q[r]),
      .v_i   (v_q[r]),
      .t_i   (t_q[r]),
      .acc_o (acc[r])
    );
  end

  // sign, magnitude and saturation stage
  apt_pkg::apt_div_t       div_d, div_q;
  logic                    div_vld_q;
  logic                    known, proj, wneg, fits;
  logic [AW-1:0]           wabs, nabs;
  logic signed [AW-1:0]    s;
  logic [AW-1:CW-1]        hi;
  logic [MW+F-1:0]         nn;

  always_comb begin
    div_d = '0;
    proj  = (op_q[2] == apt_pkg::OP_PROJ);
    known = (op_q[2] == apt_pkg::OP_AFFINE) || (op_q[2] == apt_pkg::OP_ROT) ||
            (op_q[2] == apt_pkg::OP_INV_RIGID) || (op_q[2] == apt_pkg::OP_TRANS_ROT) ||
            proj;
    wneg  = acc[3][AW-1];
    wabs  = wneg ? (~acc[3] + AW'(1)) : acc[3];
    div_d.dm        = wabs[MW-1:0];
    div_d.meta.proj = proj;
    div_d.meta.zdiv = proj && (acc[3] == '0);
    s    = '0;
    hi   = '0;
    fits = 1'b1;
    nabs = '0;
    nn   = '0;
    for (int l = 0; l < 3; l++) begin
      s    = $signed(acc[l]) >>> F;
      hi   = s[AW-1:CW-1];
      fits = (&hi) || !(|hi);
      if (!known) begin
        div_d.meta.q_np[l] = '0;
      end else if (fits) begin
        div_d.meta.q_np[l] = s[CW-1:0];
      end else begin
        div_d.meta.q_np[l] = s[AW-1] ? apt_pkg::SMIN : apt_pkg::SMAX;
        div_d.meta.sat_np  = 1'b1;
      end
      nabs = acc[l][AW-1] ? (~acc[l] + AW'(1)) : acc[l];
      nn   = {nabs[MW-1:0], {F{1'b0}}};
      div_d.lane[l].rem = MW'(nn[MW+F-1:QW]);
      div_d.lane[l].qn  = nn[QW-1:0];
      div_d.lane[l].ovf = 1'b0;
      div_d.lane[l].neg = acc[l][AW-1] ^ wneg;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      div_q <= div_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_vld_q <= 1'b0;
    end else if (en) begin
      div_vld_q <= vld_q[2];
    end
  end

  // divider
  logic              dv;
  apt_pkg::apt_div_t dd;

  apt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (div_vld_q),
    .data_i  (div_q),
    .valid_o (dv),
    .data_o  (dd)
  );

  // final sign and saturation, output register
  apt_pkg::apt_out_t out_d, out_q;
  logic              out_vld_q;
  logic [CW-1:0]     qd [3];
  logic              sat_dv;

  always_comb begin
    sat_dv = 1'b0;
    for (int l = 0; l < 3; l++) begin
      if (dd.lane[l].ovf) begin
        qd[l]  = dd.lane[l].neg ? apt_pkg::SMIN : apt_pkg::SMAX;
        sat_dv = 1'b1;
      end else if (dd.lane[l].neg) begin
        if (dd.lane[l].qn > apt_pkg::SMIN) begin
          qd[l]  = apt_pkg::SMIN;
          sat_dv = 1'b1;
        end else begin
          qd[l] = ~dd.lane[l].qn + CW'(1);
        end
      end else if (dd.lane[l].qn[CW-1]) begin
        qd[l]  = apt_pkg::SMAX;
        sat_dv = 1'b1;
      end else begin
        qd[l] = dd.lane[l].qn;
      end
    end
    out_d = '0;
    if (!dd.meta.proj) begin
      out_d.qx        = dd.meta.q_np[0];
      out_d.qy        = dd.meta.q_np[1];
      out_d.qz        = dd.meta.q_np[2];
      out_d.saturated = dd.meta.sat_np;
    end else if (dd.meta.zdiv) begin
      out_d.zero_divisor = 1'b1;
    end else begin
      out_d.qx        = qd[0];
      out_d.qy        = qd[1];
      out_d.qz        = qd[2];
      out_d.saturated = sat_dv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  `APT_ASSERT_IMPL(a_zdiv_zero, clk_i, rst_ni, out_valid_o && out_data_o.zero_divisor, (out_data_o.qx == 0) && (out_data_o.qy == 0) && (out_data_o.qz == 0) && !out_data_o.saturated)
  `APT_ASSERT(a_no_stall_free, clk_i, rst_ni, !out_stall_i |-> !in_stall_o)

endmodule
